[rtl/brpc_pkg.sv]
// Shared constants, types and the margin test for the blocked row pair comparator.
package brpc_pkg;

    // Size limits of a row and of the block split
    localparam int MAX_ROW_LENGTH = 8192;
    localparam int MAX_BLOCKS     = 64;

    // Register and field widths
    localparam int ROW_LENGTH_W  = 14;
    localparam int BLOCK_COUNT_W = 7;
    localparam int MARGIN_W      = 16;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_INDEX_W   = 2;
    localparam int VERDICT_W     = 2;
    localparam int BLOCK_CODE_W  = 7;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_LENGTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MARGIN_SQ   = 2'd2;

    // Register reset values
    localparam logic [ROW_LENGTH_W-1:0]  ROW_LENGTH_RESET  = 14'd5000;
    localparam logic [BLOCK_COUNT_W-1:0] BLOCK_COUNT_RESET = 7'd48;
    localparam logic [MARGIN_W-1:0]      MARGIN_SQ_RESET   = 16'd8722;

    // Verdict codes
    localparam logic [VERDICT_W-1:0] VERDICT_UNDECIDED = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_FIRST     = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_SECOND    = 2'd2;

    // Deciding block codes
    localparam logic [BLOCK_CODE_W-1:0] CODE_WHOLE_ROW = 7'd0;
    localparam logic [BLOCK_CODE_W-1:0] CODE_NONE      = 7'd65;

    // Derived widths
    localparam int POS_W      = $clog2(MAX_ROW_LENGTH);
    localparam int TAKEN_W    = $clog2(MAX_ROW_LENGTH + 1);
    localparam int DIFF_W     = TAKEN_W + 1;
    localparam int BIDX_W     = BLOCK_CODE_W;
    localparam int BLOCKS_W   = $clog2(MAX_BLOCKS + 1);
    localparam int END_W      = TAKEN_W + BIDX_W + BLOCKS_W + 2;
    localparam int FRACTION_W = 8;
    localparam int SQ_W       = 2 * TAKEN_W;
    localparam int RHS_W      = MARGIN_W + TAKEN_W;
    localparam int LHS_W      = SQ_W + FRACTION_W;
    localparam int JUDGE_W    = (LHS_W > RHS_W) ? LHS_W : RHS_W;

    localparam logic [BIDX_W-1:0] BIDX_MAX = {BIDX_W{1'b1}};

    // One pending margin test: a difference over a span of columns
    typedef struct packed {
        logic                     valid;
        logic signed [DIFF_W-1:0] diff;
        logic [TAKEN_W-1:0]       span;
        logic [MARGIN_W-1:0]      margin;
    } test_req_t;

    // The same test after the multiplications
    typedef struct packed {
        logic               valid;
        logic               nonzero;
        logic               negative;
        logic [SQ_W-1:0]    square;
        logic [RHS_W-1:0]   bound;
    } test_prod_t;

    // Compare 256*d*d against margin_sq*len and give the direction
    function automatic logic [VERDICT_W-1:0] judge(test_prod_t p);
        logic [JUDGE_W-1:0] lhs;
        logic [JUDGE_W-1:0] rhs;
        lhs = JUDGE_W'(p.square) << FRACTION_W;
        rhs = JUDGE_W'(p.bound);
        if (p.nonzero && (lhs > rhs))
            return p.negative ? VERDICT_SECOND : VERDICT_FIRST;
        return VERDICT_UNDECIDED;
    endfunction

endpackage

[rtl/brpc_channel_if.sv]
// Valid/ready channels that carry sample words in and result words out.
interface brpc_sample_if;
    logic valid;
    logic ready;
    logic first_row_bit;
    logic second_row_bit;

    modport source (output valid, output first_row_bit, output second_row_bit, input ready);
    modport sink   (input valid, input first_row_bit, input second_row_bit, output ready);
endinterface

interface brpc_result_if;
    logic                              valid;
    logic                              ready;
    logic [brpc_pkg::VERDICT_W-1:0]    verdict;
    logic [brpc_pkg::BLOCK_CODE_W-1:0] deciding_block;

    modport source (output valid, output verdict, output deciding_block, input ready);
    modport sink   (input valid, input verdict, input deciding_block, output ready);
endinterface

[rtl/brpc_judge_stage.sv]
// Pipeline stage that squares a difference and scales the margin by the span.
module brpc_judge_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  brpc_pkg::test_req_t  req,
    output brpc_pkg::test_prod_t prod
);
    import brpc_pkg::*;

    logic [DIFF_W-1:0]  mag_full;
    logic [TAKEN_W-1:0] mag;
    test_prod_t         prod_next;
    logic               valid_reg;
    test_prod_t         data_reg;

    // Take the magnitude and form both products
    always_comb
    begin
        mag_full           = req.diff[DIFF_W-1] ? DIFF_W'(-req.diff) : DIFF_W'(req.diff);
        mag                = mag_full[TAKEN_W-1:0];
        prod_next.valid    = req.valid;
        prod_next.nonzero  = (req.diff != '0);
        prod_next.negative = req.diff[DIFF_W-1];
        prod_next.square   = SQ_W'(mag) * SQ_W'(mag);
        prod_next.bound    = RHS_W'(req.margin) * RHS_W'(req.span);
    end

    // Hold the valid flag under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= prod_next.valid;
    end

    // Capture the products
    always_ff @(posedge clk)
    begin
        if (advance)
            data_reg <= prod_next;
    end

    always_comb
    begin
        prod       = data_reg;
        prod.valid = valid_reg;
    end

endmodule

[rtl/blocked_row_pair_comparator.sv]
// Top level of the blocked row pair comparator.
//
// Takes one column word (a bit of each row) per clock and keeps running
// row-sum differences over the whole row and over the current block; block i
// starts at column floor(L*i/B). Block ends are found by comparing
// L*(i+1) with (columns+1)*B, so no divider is needed. Each finished span goes
// through a multiply stage and a compare stage; a row's result word passes
// the pending-test and multiply-stage registers into the output register,
// and further columns keep flowing while it waits. Sustained rate is one
// column per clock; samples.ready drops only when a second row result reaches
// the last stage while the previous one has not yet been taken. Register
// writes apply from the next column taken; margin_sq is captured per column.
module blocked_row_pair_comparator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [brpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [brpc_pkg::CFG_DATA_W-1:0]     cfg_data,
    brpc_sample_if.sink                         samples,
    brpc_result_if.source                       result
);
    import brpc_pkg::*;

    // Configuration registers
    logic [ROW_LENGTH_W-1:0]  row_length_reg;
    logic [BLOCK_COUNT_W-1:0] block_count_reg;
    logic [MARGIN_W-1:0]      margin_sq_reg;

    // Row state
    logic [POS_W-1:0]         pos_reg,   pos_next;
    logic signed [DIFF_W-1:0] whole_reg, whole_next;
    logic signed [DIFF_W-1:0] blk_reg,   blk_next;
    logic [POS_W-1:0]         bstart_reg, bstart_next;
    logic [BIDX_W-1:0]        bidx_reg,  bidx_next;

    // Stage one outputs
    logic                     advance;
    logic                     accept;
    logic [31:0]              len32;
    logic [31:0]              blocks32;
    logic [TAKEN_W-1:0]       len_eff;
    logic [BLOCKS_W-1:0]      blocks_eff;
    logic [TAKEN_W-1:0]       taken;
    logic [TAKEN_W-1:0]       span;
    logic [END_W-1:0]         end_scaled;
    logic [END_W-1:0]         taken_scaled;
    logic                     block_done;
    logic                     row_done;
    logic signed [DIFF_W-1:0] whole_sum;
    logic signed [DIFF_W-1:0] blk_sum;
    test_req_t                blk_req_next,  whole_req_next;
    logic                     blk_req_valid_reg, whole_req_valid_reg;
    test_req_t                blk_req_data_reg,  whole_req_data_reg;
    test_req_t                blk_req,           whole_req;
    logic [BIDX_W-1:0]        p_code_reg,    q_code_reg;

    // Stage two outputs
    test_prod_t               blk_prod, whole_prod;

    // Verdict stage
    logic [VERDICT_W-1:0]     blk_verdict, whole_verdict;
    logic [VERDICT_W-1:0]     fb_verdict_reg, fb_verdict_next, fb_verdict_upd;
    logic [BLOCK_CODE_W-1:0]  fb_code_reg,    fb_code_next,    fb_code_upd;
    logic                     load_result;
    logic                     out_valid_reg,   out_valid_next;
    logic [VERDICT_W-1:0]     out_verdict_reg, out_verdict_next;
    logic [BLOCK_CODE_W-1:0]  out_block_reg,   out_block_next;

    // Stall only when a second result would overwrite an untaken one
    assign advance       = !(whole_prod.valid && out_valid_reg && !result.ready);
    assign accept        = samples.valid && advance;
    assign samples.ready = advance;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg  <= ROW_LENGTH_RESET;
            block_count_reg <= BLOCK_COUNT_RESET;
            margin_sq_reg   <= MARGIN_SQ_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ROW_LENGTH:  row_length_reg  <= cfg_data[ROW_LENGTH_W-1:0];
                CFG_BLOCK_COUNT: block_count_reg <= cfg_data[BLOCK_COUNT_W-1:0];
                CFG_MARGIN_SQ:   margin_sq_reg   <= cfg_data[MARGIN_W-1:0];
                default:         ;
            endcase
        end
    end

    // Clamp row length and block count
    always_comb
    begin
        len32 = 32'(row_length_reg);
        if (len32 == 32'd0)
            len32 = 32'd1;
        if (len32 > 32'(MAX_ROW_LENGTH))
            len32 = 32'(MAX_ROW_LENGTH);
        blocks32 = 32'(block_count_reg);
        if (blocks32 == 32'd0)
            blocks32 = 32'd1;
        if (blocks32 > len32)
            blocks32 = len32;
        if (blocks32 > 32'(MAX_BLOCKS))
            blocks32 = 32'(MAX_BLOCKS);
        len_eff    = len32[TAKEN_W-1:0];
        blocks_eff = blocks32[BLOCKS_W-1:0];
    end

    // Accumulate the column and find block and row ends
    always_comb
    begin
        whole_sum = whole_reg;
        blk_sum   = blk_reg;
        if (samples.first_row_bit && !samples.second_row_bit)
        begin
            whole_sum = whole_reg + DIFF_W'(1);
            blk_sum   = blk_reg + DIFF_W'(1);
        end
        else if (!samples.first_row_bit && samples.second_row_bit)
        begin
            whole_sum = whole_reg - DIFF_W'(1);
            blk_sum   = blk_reg - DIFF_W'(1);
        end

        taken        = TAKEN_W'(pos_reg) + TAKEN_W'(1);
        span         = (taken > TAKEN_W'(bstart_reg)) ? taken - TAKEN_W'(bstart_reg) : '0;
        end_scaled   = END_W'(len_eff) * (END_W'(bidx_reg) + END_W'(1));
        taken_scaled = (END_W'(taken) + END_W'(1)) * END_W'(blocks_eff);
        block_done   = end_scaled < taken_scaled;
        row_done     = taken >= len_eff;

        blk_req_next.valid    = accept && block_done;
        blk_req_next.diff     = blk_sum;
        blk_req_next.span     = span;
        blk_req_next.margin   = margin_sq_reg;
        whole_req_next.valid  = accept && row_done;
        whole_req_next.diff   = whole_sum;
        whole_req_next.span   = taken;
        whole_req_next.margin = margin_sq_reg;
    end

    // Advance the row state
    always_comb
    begin
        pos_next    = pos_reg;
        whole_next  = whole_reg;
        blk_next    = blk_reg;
        bstart_next = bstart_reg;
        bidx_next   = bidx_reg;
        if (accept)
        begin
            pos_next   = taken[POS_W-1:0];
            whole_next = whole_sum;
            blk_next   = blk_sum;
            if (block_done)
            begin
                blk_next    = '0;
                bstart_next = taken[POS_W-1:0];
                if (bidx_reg != BIDX_MAX)
                    bidx_next = bidx_reg + BIDX_W'(1);
            end
            if (row_done)
            begin
                pos_next    = '0;
                whole_next  = '0;
                blk_next    = '0;
                bstart_next = '0;
                bidx_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            whole_reg  <= '0;
            blk_reg    <= '0;
            bstart_reg <= '0;
            bidx_reg   <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            whole_reg  <= whole_next;
            blk_reg    <= blk_next;
            bstart_reg <= bstart_next;
            bidx_reg   <= bidx_next;
        end
    end

    // Register the pending tests
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_req_valid_reg   <= 1'b0;
            whole_req_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            blk_req_valid_reg   <= blk_req_next.valid;
            whole_req_valid_reg <= whole_req_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            blk_req_data_reg   <= blk_req_next;
            whole_req_data_reg <= whole_req_next;
            p_code_reg         <= bidx_reg + BIDX_W'(1);
            q_code_reg         <= p_code_reg;
        end
    end

    always_comb
    begin
        blk_req         = blk_req_data_reg;
        blk_req.valid   = blk_req_valid_reg;
        whole_req       = whole_req_data_reg;
        whole_req.valid = whole_req_valid_reg;
    end

    // Multiply stages
    brpc_judge_stage u_blk_judge (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .req     (blk_req),
        .prod    (blk_prod)
    );

    brpc_judge_stage u_whole_judge (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .req     (whole_req),
        .prod    (whole_prod)
    );

    // Resolve verdicts: a whole-row verdict wins over the earliest deciding block
    always_comb
    begin
        blk_verdict   = blk_prod.valid ? judge(blk_prod) : VERDICT_UNDECIDED;
        whole_verdict = judge(whole_prod);

        fb_verdict_upd = fb_verdict_reg;
        fb_code_upd    = fb_code_reg;
        if ((blk_verdict != VERDICT_UNDECIDED) && (fb_code_reg == CODE_NONE))
        begin
            fb_verdict_upd = blk_verdict;
            fb_code_upd    = q_code_reg;
        end

        load_result = advance && whole_prod.valid;

        priority if (whole_verdict != VERDICT_UNDECIDED)
        begin
            out_verdict_next = whole_verdict;
            out_block_next   = CODE_WHOLE_ROW;
        end
        else if (fb_code_upd != CODE_NONE)
        begin
            out_verdict_next = fb_verdict_upd;
            out_block_next   = fb_code_upd;
        end
        else
        begin
            out_verdict_next = VERDICT_UNDECIDED;
            out_block_next   = CODE_NONE;
        end

        fb_verdict_next = fb_verdict_reg;
        fb_code_next    = fb_code_reg;
        if (load_result)
        begin
            fb_verdict_next = VERDICT_UNDECIDED;
            fb_code_next    = CODE_NONE;
        end
        else if (advance)
        begin
            fb_verdict_next = fb_verdict_upd;
            fb_code_next    = fb_code_upd;
        end

        if (load_result)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_verdict_reg <= VERDICT_UNDECIDED;
            fb_code_reg    <= CODE_NONE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            fb_verdict_reg <= fb_verdict_next;
            fb_code_reg    <= fb_code_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Hold the result word
    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            out_verdict_reg <= out_verdict_next;
            out_block_reg   <= out_block_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.verdict        = out_verdict_reg;
    assign result.deciding_block = out_block_reg;

    // A recorded block always carries a direction
    a_fb_has_direction: assert property (@(posedge clk) disable iff (!rst_n)
        (fb_code_reg != CODE_NONE) |->
            (fb_verdict_reg == VERDICT_FIRST || fb_verdict_reg == VERDICT_SECOND))
        else $error("recorded block without direction");

    // An undecided result names no block
    a_undecided_none: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_verdict_reg == VERDICT_UNDECIDED) |->
            (out_block_reg == CODE_NONE))
        else $error("undecided result with a block code");

    // Input stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !samples.ready |-> (out_valid_reg && whole_prod.valid))
        else $error("input stalled without a waiting result");

    // First block always starts at column zero
    a_first_block_start: assert property (@(posedge clk) disable iff (!rst_n)
        (bidx_reg == '0) |-> (bstart_reg == '0))
        else $error("first block starts past column zero");

endmodule

[test/blocked_row_pair_comparator_tb.sv]
// Testbench for the blocked row pair comparator: directed table, then random rows.
`timescale 1ns / 100ps

module blocked_row_pair_comparator_tb;
    import brpc_pkg::*;

    localparam int     ITEM_TARGET   = 1150;
    localparam int     FINAL_COLUMNS = 300;
    localparam int     DRAIN_CYCLES  = 8;
    localparam longint RUN_LIMIT_NS  = 64'd10_000_000;

    typedef struct packed {
        logic [VERDICT_W-1:0]    verdict;
        logic [BLOCK_CODE_W-1:0] code;
    } row_result_t;

    typedef enum logic { DO_COLUMN, DO_WRITE } step_kind_t;

    typedef struct packed {
        step_kind_t              kind;
        logic [CFG_INDEX_W-1:0]  index;
        logic [CFG_DATA_W-1:0]   data;
        logic                    first_bit;
        logic                    second_bit;
        logic                    typed;
        logic [VERDICT_W-1:0]    verdict;
        logic [BLOCK_CODE_W-1:0] code;
    } directed_step_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    brpc_sample_if samples_if ();
    brpc_result_if result_if ();

    blocked_row_pair_comparator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samples_if),
        .result    (result_if)
    );

    // Register copies and row state of the predictor
    int unsigned cur_row_length  = ROW_LENGTH_RESET;
    int unsigned cur_block_count = BLOCK_COUNT_RESET;
    int unsigned cur_margin_sq   = MARGIN_SQ_RESET;
    int unsigned cols_taken;
    int          row_diff;
    int          span_diff;
    int unsigned span_start;
    int unsigned span_index;
    logic [VERDICT_W-1:0]    early_verdict;
    logic [BLOCK_CODE_W-1:0] early_code;

    row_result_t row_verdicts_due [$];
    int          columns_sent = 0;
    int          bad_rows     = 0;
    bit          stall_free   = 1'b0;

    // Directed words: typed results only where the outcome is obvious
    directed_step_t directed_plan [] = '{
        // reset settings, no block end within the first columns
        '{DO_COLUMN, CFG_ROW_LENGTH, 16'd0, 1'b1, 1'b0, 1'b0, VERDICT_UNDECIDED, CODE_NONE},
        '{DO_COLUMN, CFG_ROW_LENGTH, 16'd0, 1'b1, 1'b0, 1'b0, VERDICT_UNDECIDED, CODE_NONE},
        '{DO_COLUMN, CFG_ROW_LENGTH, 16'd0, 1'b1, 1'b0, 1'b0, VERDICT_UNDECIDED, CODE_NONE},
        // shorten the row mid-way: it ends on the next column, undecided
        '{DO_WRITE,  CFG_ROW_LENGTH, 16'd1, 1'b0, 1'b0, 1'b0, VERDICT_UNDECIDED, CODE_NONE},
        '{DO_COLUMN, CFG_ROW_LENGTH, 16'd0, 1'b1, 1'b0, 1'b1, VERDICT_UNDECIDED, CODE_NONE},
        // zero margin: any nonzero difference decides on the whole row
        '{DO_WRITE,  CFG_MARGIN_SQ,  16'd0, 1'b0, 1'b0, 1'b0, VERDICT_UNDECIDED, CODE_NONE},
        '{DO_COLUMN, CFG_ROW_LENGTH, 16'd0, 1'b1, 1'b0, 1'b1, VERDICT_FIRST, CODE_WHOLE_ROW},
        '{DO_COLUMN, CFG_ROW_LENGTH, 16'd0, 1'b0, 1'b1, 1'b1, VERDICT_SECOND, CODE_WHOLE_ROW},
        '{DO_COLUMN, CFG_ROW_LENGTH, 16'd0, 1'b0, 1'b0, 1'b1, VERDICT_UNDECIDED, CODE_NONE},
        '{DO_COLUMN, CFG_ROW_LENGTH, 16'd0, 1'b1, 1'b1, 1'b1, VERDICT_UNDECIDED, CODE_NONE},
        // largest margin never decides a single column
        '{DO_WRITE,  CFG_MARGIN_SQ,  16'hFFFF, 1'b0, 1'b0, 1'b0, VERDICT_UNDECIDED, CODE_NONE},
        '{DO_COLUMN, CFG_ROW_LENGTH, 16'd0, 1'b1, 1'b0, 1'b1, VERDICT_UNDECIDED, CODE_NONE},
        // strict compare: 256 beats 255 but not 256
        '{DO_WRITE,  CFG_MARGIN_SQ,  16'd255, 1'b0, 1'b0, 1'b0, VERDICT_UNDECIDED, CODE_NONE},
        '{DO_COLUMN, CFG_ROW_LENGTH, 16'd0, 1'b0, 1'b1, 1'b1, VERDICT_SECOND, CODE_WHOLE_ROW},
        '{DO_WRITE,  CFG_MARGIN_SQ,  16'd256, 1'b0, 1'b0, 1'b0, VERDICT_UNDECIDED, CODE_NONE},
        '{DO_COLUMN, CFG_ROW_LENGTH, 16'd0, 1'b1, 1'b0, 1'b1, VERDICT_UNDECIDED, CODE_NONE},
        // four blocks of one column: earliest deciding block wins
        '{DO_WRITE,  CFG_MARGIN_SQ,   16'd255, 1'b0, 1'b0, 1'b0, VERDICT_UNDECIDED, CODE_NONE},
        '{DO_WRITE,  CFG_ROW_LENGTH,  16'd4, 1'b0, 1'b0, 1'b0, VERDICT_UNDECIDED, CODE_NONE},
        '{DO_WRITE,  CFG_BLOCK_COUNT, 16'd4, 1'b0, 1'b0, 1'b0, VERDICT_UNDECIDED, CODE_NONE},
        '{DO_COLUMN, CFG_ROW_LENGTH, 16'd0, 1'b1, 1'b0, 1'b0, VERDICT_UNDECIDED, CODE_NONE},
        '{DO_COLUMN, CFG_ROW_LENGTH, 16'd0, 1'b0, 1'b1, 1'b0, VERDICT_UNDECIDED, CODE_NONE},
        '{DO_COLUMN, CFG_ROW_LENGTH, 16'd0, 1'b0, 1'b0, 1'b0, VERDICT_UNDECIDED, CODE_NONE},
        '{DO_COLUMN, CFG_ROW_LENGTH, 16'd0, 1'b0, 1'b0, 1'b0, VERDICT_UNDECIDED, CODE_NONE},
        '{DO_COLUMN, CFG_ROW_LENGTH, 16'd0, 1'b0, 1'b0, 1'b0, VERDICT_UNDECIDED, CODE_NONE},
        '{DO_COLUMN, CFG_ROW_LENGTH, 16'd0, 1'b0, 1'b1, 1'b0, VERDICT_UNDECIDED, CODE_NONE},
        '{DO_COLUMN, CFG_ROW_LENGTH, 16'd0, 1'b1, 1'b0, 1'b0, VERDICT_UNDECIDED, CODE_NONE},
        '{DO_COLUMN, CFG_ROW_LENGTH, 16'd0, 1'b0, 1'b0, 1'b0, VERDICT_UNDECIDED, CODE_NONE},
        // drop to one block mid-row: the open block never reaches its end
        '{DO_COLUMN, CFG_ROW_LENGTH, 16'd0, 1'b1, 1'b0, 1'b0, VERDICT_UNDECIDED, CODE_NONE},
        '{DO_COLUMN, CFG_ROW_LENGTH, 16'd0, 1'b1, 1'b0, 1'b0, VERDICT_UNDECIDED, CODE_NONE},
        '{DO_WRITE,  CFG_BLOCK_COUNT, 16'd0, 1'b0, 1'b0, 1'b0, VERDICT_UNDECIDED, CODE_NONE},
        '{DO_COLUMN, CFG_ROW_LENGTH, 16'd0, 1'b0, 1'b1, 1'b0, VERDICT_UNDECIDED, CODE_NONE},
        '{DO_COLUMN, CFG_ROW_LENGTH, 16'd0, 1'b0, 1'b1, 1'b0, VERDICT_UNDECIDED, CODE_NONE}
    };

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop if the run hangs
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("blocked_row_pair_comparator: mismatch");
        $finish;
    end

    // Row length as the block sees it
    function automatic int unsigned effective_length();
        if (cur_row_length == 0)
            return 1;
        if (cur_row_length > MAX_ROW_LENGTH)
            return MAX_ROW_LENGTH;
        return cur_row_length;
    endfunction

    // Return the row state to its idle values
    function automatic void clear_row();
        cols_taken    = 0;
        row_diff      = 0;
        span_diff     = 0;
        span_start    = 0;
        span_index    = 0;
        early_verdict = VERDICT_UNDECIDED;
        early_code    = CODE_NONE;
    endfunction

    // Decide when 256*d*d exceeds margin_sq*span, direction from the sign of d
    function automatic logic [VERDICT_W-1:0] margin_verdict(int diff, int unsigned span);
        longint unsigned mag;
        longint unsigned bound;
        if (diff == 0)
            return VERDICT_UNDECIDED;
        mag   = (diff > 0) ? longint'(diff) : longint'(-diff);
        bound = cur_margin_sq;
        bound = bound * span;
        if (((mag * mag) << FRACTION_W) > bound)
            return (diff > 0) ? VERDICT_FIRST : VERDICT_SECOND;
        return VERDICT_UNDECIDED;
    endfunction

    // Advance the row by one column word; returns 1 when the row closes
    function automatic bit score_column(logic first_bit, logic second_bit,
                                        output row_result_t row_out);
        int unsigned          len_eff;
        int unsigned          blocks;
        int unsigned          block_end;
        int                   delta;
        logic [VERDICT_W-1:0] v;
        row_out = '{VERDICT_UNDECIDED, CODE_NONE};
        len_eff = effective_length();
        blocks  = (cur_block_count == 0) ? 1 : cur_block_count;
        if (blocks > len_eff)
            blocks = len_eff;
        if (blocks > MAX_BLOCKS)
            blocks = MAX_BLOCKS;

        delta      = int'(first_bit) - int'(second_bit);
        row_diff  += delta;
        span_diff += delta;
        cols_taken++;

        // close the current block once its scaled end is reached
        block_end = len_eff * (span_index + 1) / blocks;
        if (cols_taken >= block_end)
        begin
            v = margin_verdict(span_diff, cols_taken - span_start);
            if (v != VERDICT_UNDECIDED && early_code == CODE_NONE)
            begin
                early_verdict = v;
                early_code    = BLOCK_CODE_W'(span_index + 1);
            end
            span_diff  = 0;
            span_start = cols_taken;
            if (span_index < BIDX_MAX)
                span_index++;
        end

        if (cols_taken < len_eff)
            return 1'b0;

        // whole row first, then the earliest deciding block
        v = margin_verdict(row_diff, cols_taken);
        if (v != VERDICT_UNDECIDED)
            row_out = '{v, CODE_WHOLE_ROW};
        else if (early_code != CODE_NONE)
            row_out = '{early_verdict, early_code};
        clear_row();
        return 1'b1;
    endfunction

    task automatic note_error(string what);
        bad_rows++;
        if (bad_rows <= 10)
            $display("%0t: %s", $time, what);
    endtask

    // Write one register and mirror it into the predictor
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_ROW_LENGTH:  cur_row_length  = data[ROW_LENGTH_W-1:0];
            CFG_BLOCK_COUNT: cur_block_count = data[BLOCK_COUNT_W-1:0];
            CFG_MARGIN_SQ:   cur_margin_sq   = data[MARGIN_W-1:0];
            default: ;
        endcase
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one column word, hold it until taken, then predict
    task automatic send_column(logic first_bit, logic second_bit,
                               logic typed, row_result_t typed_row);
        row_result_t predicted;
        bit          row_closed;
        while (!stall_free && $urandom_range(0, 99) < 8)
        begin
            samples_if.valid <= 1'b0;
            @(posedge clk);
        end
        samples_if.valid          <= 1'b1;
        samples_if.first_row_bit  <= first_bit;
        samples_if.second_row_bit <= second_bit;
        @(posedge clk);
        while (!samples_if.ready)
            @(posedge clk);
        row_closed = score_column(first_bit, second_bit, predicted);
        if (typed)
            row_verdicts_due.insert(row_verdicts_due.size(), typed_row);
        else if (row_closed)
            row_verdicts_due.insert(row_verdicts_due.size(), predicted);
        columns_sent++;
    endtask

    // Drop valid, wait for every pending row result, then let the pipe empty
    task automatic settle();
        samples_if.valid <= 1'b0;
        while (row_verdicts_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Result side: random stalls, compare each taken word with the oldest prediction
    always @(posedge clk)
    begin : collect_results
        row_result_t want;
        if (!rst_n)
            result_if.ready <= 1'b0;
        else
        begin
            result_if.ready <= stall_free || ($urandom_range(0, 99) >= 8);
            if (result_if.valid && result_if.ready)
            begin
                if (row_verdicts_due.size() == 0)
                    note_error($sformatf("unexpected result word verdict=%0d block=%0d",
                                         result_if.verdict, result_if.deciding_block));
                else
                begin
                    want = row_verdicts_due.pop_front();
                    if (result_if.verdict !== want.verdict
                        || result_if.deciding_block !== want.code)
                        note_error($sformatf(
                            "row result differs: expected verdict=%0d block=%0d, got %0d/%0d",
                            want.verdict, want.code,
                            result_if.verdict, result_if.deciding_block));
                end
            end
        end
    end

    // Stimulus
    initial
    begin : stimulus
        int unsigned len_eff;
        int unsigned remaining;
        int unsigned run;
        int unsigned p_first;
        int unsigned p_second;
        int unsigned setting;
        int          random_goal;
        int          random_start;

        rst_n                     = 1'b0;
        cfg_write                 = 1'b0;
        cfg_index                 = CFG_ROW_LENGTH;
        cfg_data                  = '0;
        samples_if.valid          = 1'b0;
        samples_if.first_row_bit  = 1'b0;
        samples_if.second_row_bit = 1'b0;
        clear_row();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table
        foreach (directed_plan[i])
        begin
            if (directed_plan[i].kind == DO_WRITE)
            begin
                settle();
                write_reg(directed_plan[i].index, directed_plan[i].data);
            end
            else
                send_column(directed_plan[i].first_bit, directed_plan[i].second_bit,
                            directed_plan[i].typed,
                            '{directed_plan[i].verdict, directed_plan[i].code});
        end

        // random phases: mostly whole rows, some cut short so settings change mid-row
        random_goal  = columns_sent + ITEM_TARGET;
        random_start = columns_sent;
        while (columns_sent < random_goal)
        begin
            settle();
            // one long stretch with no idling on either side
            stall_free <= (columns_sent - random_start >= 300)
                          && (columns_sent - random_start < 700);

            if ($urandom_range(0, 9) < 6)
            begin
                case ($urandom_range(0, 9))
                    0:       setting = 0;
                    1, 2:    setting = $urandom_range(25, 400);
                    default: setting = $urandom_range(1, 24);
                endcase
                write_reg(CFG_ROW_LENGTH, CFG_DATA_W'(setting));
            end
            if ($urandom_range(0, 9) < 6)
            begin
                case ($urandom_range(0, 9))
                    0:       setting = 0;
                    1:       setting = 127;
                    2:       setting = MAX_BLOCKS;
                    3, 4:    setting = $urandom_range(0, 127);
                    5:       setting = $urandom_range(9, 63);
                    default: setting = $urandom_range(1, 8);
                endcase
                write_reg(CFG_BLOCK_COUNT, CFG_DATA_W'(setting));
            end
            if ($urandom_range(0, 9) < 6)
            begin
                case ($urandom_range(0, 9))
                    0:          setting = 0;
                    1:          setting = 16'hFFFF;
                    2, 3:       setting = $urandom_range(0, 65535);
                    4, 5, 6:    setting = $urandom_range(0, 255);
                    default:    setting = $urandom_range(256, 4095);
                endcase
                write_reg(CFG_MARGIN_SQ, CFG_DATA_W'(setting));
            end

            len_eff   = effective_length();
            remaining = (cols_taken < len_eff) ? len_eff - cols_taken : 1;
            if ($urandom_range(0, 3) != 0)
                run = remaining + len_eff * $urandom_range(0, 2);
            else
                run = $urandom_range(1, remaining);
            if (int'(run) > random_goal - columns_sent)
                run = random_goal - columns_sent;

            // biased rows so that verdicts of both directions show up
            p_first  = $urandom_range(0, 100);
            p_second = $urandom_range(0, 100);
            repeat (run)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    p_first  = $urandom_range(0, 100);
                    p_second = $urandom_range(0, 100);
                end
                send_column($urandom_range(0, 99) < p_first, $urandom_range(0, 99) < p_second,
                            1'b0, '{VERDICT_UNDECIDED, CODE_NONE});
            end
        end

        // close any open row so the long row starts at column zero
        settle();
        stall_free <= 1'b0;
        write_reg(CFG_ROW_LENGTH, 16'd1);
        send_column(1'b0, 1'b0, 1'b0, '{VERDICT_UNDECIDED, CODE_NONE});

        // long row, register value above the clamp: blocks of 128 columns, then cut short
        settle();
        write_reg(CFG_ROW_LENGTH, 16'h3FFF);
        write_reg(CFG_BLOCK_COUNT, 16'd127);
        write_reg(CFG_MARGIN_SQ, CFG_DATA_W'($urandom_range(0, 4095)));
        remaining = FINAL_COLUMNS;
        p_first   = $urandom_range(30, 70);
        p_second  = $urandom_range(30, 70);
        repeat (remaining)
        begin
            if ($urandom_range(0, 199) == 0)
            begin
                p_first  = $urandom_range(0, 100);
                p_second = $urandom_range(0, 100);
            end
            send_column($urandom_range(0, 99) < p_first, $urandom_range(0, 99) < p_second,
                        1'b0, '{VERDICT_UNDECIDED, CODE_NONE});
        end
        settle();
        write_reg(CFG_ROW_LENGTH, 16'd1);
        send_column(1'b1, 1'b0, 1'b0, '{VERDICT_UNDECIDED, CODE_NONE});

        settle();
        if (bad_rows == 0)
            $display("blocked_row_pair_comparator: match");
        else
            $display("blocked_row_pair_comparator: mismatch");
        $finish;
    end

endmodule
